// ----- sv/ccms_pkg.sv -----
// Shared widths, register indexes and the character-class compare for the motif scanner.
`default_nettype none

package ccms_pkg;

  // Field widths
  localparam int SYM_W      = 8;
  localparam int START_W    = 16;
  localparam int PLEN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CLASS_W    = 60;

  // Number of class registers and listed bytes per class
  localparam int NUM_CLASSES     = 7;
  localparam int CHARS_PER_CLASS = 7;

  // Class register packing
  localparam int CLASS_CNT_W    = 3;
  localparam int CLASS_CNT_LSB  = 56;
  localparam int CLASS_EXCL_BIT = 59;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_0        = 3'd1;

  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [SYM_W-1:0]   sym_t;

  // True when the symbol belongs to the class (inclusion or exclusion)
  function automatic logic class_hit(input class_t cls, input sym_t sym);
    logic [CLASS_CNT_W-1:0] cnt;
    logic                   seen;
    cnt  = cls[CLASS_CNT_LSB +: CLASS_CNT_W];
    seen = 1'b0;
    if (cnt > CLASS_CNT_W'(CHARS_PER_CLASS)) begin
      cnt = CLASS_CNT_W'(CHARS_PER_CLASS);
    end
    for (int k = 0; k < CHARS_PER_CLASS; k++) begin
      if ((CLASS_CNT_W'(k) < cnt) && (cls[SYM_W*k +: SYM_W] == sym)) begin
        seen = 1'b1;
      end
    end
    return cls[CLASS_EXCL_BIT] ? !seen : seen;
  endfunction

endpackage

`default_nettype wire

// ----- sv/char_class_motif_scanner.sv -----
// Top level of the character-class motif scanner: history, counter, match logic, result buffer.
// A match's start position goes into the output register, or into the skid entry if that is held.
// Throughput: one symbol per cycle while in_ready_o is high; the window lengths compare in parallel.
// A two-entry result buffer keeps in_ready_o high while one result waits on the output.
// Reset (rst_ni low, asynchronous): history and counter clear, pattern length 1, classes 0,
// result buffer empty.
`default_nettype none

module char_class_motif_scanner #(
  parameter int MAX_POSITIONS = 7,
  parameter int MAX_SEQUENCE  = 65536
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // symbol channel
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [ccms_pkg::SYM_W-1:0]        symbol_i,
  input  wire                               end_of_sequence_i,
  // result channel
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [ccms_pkg::START_W-1:0]      start_position_o,
  // configuration write channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [ccms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [ccms_pkg::CLASS_W-1:0]      cfg_data_i
);
  import ccms_pkg::*;

  localparam int HIST_DEPTH = (MAX_POSITIONS > 1) ? MAX_POSITIONS - 1 : 1;
  localparam int CNT_W      = $clog2(MAX_SEQUENCE + 1);

  // Configuration registers
  logic [PLEN_W-1:0]                plen_q;
  class_t [NUM_CLASSES-1:0]         class_q;

  // Sequence state
  sym_t [HIST_DEPTH-1:0]            hist_q, hist_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;

  // Result buffer: output register plus skid entry
  logic                             out_valid_q, skid_valid_q;
  logic [START_W-1:0]               out_q, skid_q;

  logic                             in_fire, out_fire, match, cnt_open;
  logic [PLEN_W-1:0]                len_eff, len_m1;
  logic [NUM_CLASSES:0]             len_match;
  sym_t [MAX_POSITIONS-1:0]         win;
  logic [CNT_W-1:0]                 start_full;
  logic [START_W-1:0]               start_pos;

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = !skid_valid_q;
  assign in_fire          = in_valid_i && in_ready_o;
  assign out_fire         = out_valid_q && out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign start_position_o = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= PLEN_W'(1);
      class_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PATTERN_LENGTH) begin
        plen_q <= cfg_data_i[PLEN_W-1:0];
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg_index_i == REG_CLASS_0 + CFG_IDX_W'(c)) begin
          class_q[c] <= cfg_data_i;
        end
      end
    end
  end

  // Window: current symbol at age 0, history behind it
  assign win[0] = symbol_i;
  for (genvar ga = 1; ga < MAX_POSITIONS; ga++) begin : g_win
    assign win[ga] = hist_q[ga-1];
  end

  // Match result for every possible pattern length, selected below
  assign len_match[0] = 1'b0;
  for (genvar gl = 1; gl <= NUM_CLASSES; gl++) begin : g_len
    if (gl <= MAX_POSITIONS) begin : g_used
      logic [gl-1:0] pos_hit;
      for (genvar gj = 0; gj < gl; gj++) begin : g_pos
        assign pos_hit[gj] = class_hit(class_q[gj], win[gl-1-gj]);
      end
      assign len_match[gl] = &pos_hit;
    end else begin : g_unused
      assign len_match[gl] = 1'b0;
    end
  end

  // Clamp length, check window fill and counter saturation
  always_comb begin
    len_eff    = (plen_q > PLEN_W'(MAX_POSITIONS)) ? PLEN_W'(MAX_POSITIONS) : plen_q;
    len_m1     = len_eff - PLEN_W'(1);
    cnt_open   = (cnt_q < CNT_W'(MAX_SEQUENCE)) && (cnt_q >= CNT_W'(len_m1));
    match      = len_match[len_eff] && cnt_open;
    start_full = cnt_q - CNT_W'(len_m1);
    start_pos  = START_W'(start_full);
  end

  // Next history and counter
  always_comb begin
    hist_d = hist_q;
    cnt_d  = cnt_q;
    if (end_of_sequence_i) begin
      hist_d = '0;
      cnt_d  = '0;
    end else begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = symbol_i;
      if (cnt_q < CNT_W'(MAX_SEQUENCE)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      cnt_q  <= '0;
    end else if (in_fire) begin
      hist_q <= hist_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && match) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result buffer data
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && match) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= start_pos;
      end else begin
        out_q <= start_pos;
      end
    end
  end

`ifndef SYNTH
  // Skid entry is only used behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // Counter saturates at the maximum sequence length
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_SEQUENCE))
    else $error("symbol counter past saturation");

  // End of sequence clears the counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_sequence_i) |=> (cnt_q == '0))
    else $error("counter not cleared after end of sequence");

  // A match accepted into an empty buffer shows up on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && match && !out_valid_q) |=> (out_valid_o && (start_position_o == $past(start_pos))))
    else $error("match result lost or corrupted");
`endif

endmodule

`default_nettype wire
